@@ src/qtc_pkg.sv @@
package qtc_pkg;

  localparam int IN_W     = 40;
  localparam int OUT_W    = 64;
  localparam int DUR_W    = 24;
  localparam int IN_FRAC  = 16;
  localparam int OUT_FRAC = 32;
  localparam int DUR_FRAC = 16;

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(163840);

  // Powers of the duration.
  localparam int D2_W = 2 * DUR_W;
  localparam int D3_W = 3 * DUR_W;
  localparam int D4_W = 4 * DUR_W;
  localparam int D5_W = 5 * DUR_W;

  // Boundary terms and numerators (signed).
  localparam int DIFF_W = IN_W + 1;
  localparam int PRD_W  = IN_W + DUR_W;
  localparam int H0P_W  = 82;
  localparam int H1_W   = 65;
  localparam int H1_LO  = 33;
  localparam int TERM_W = 90;
  localparam int NUM_W  = 94;
  localparam int MAG_W  = NUM_W - 1;

  // Long division of |n| * 2^L by d^k * 2^(IN_FRAC+1).
  localparam int RSH     = IN_FRAC + 1;
  localparam int C3_LSH  = DUR_FRAC + OUT_FRAC;
  localparam int C4_LSH  = 2 * DUR_FRAC + OUT_FRAC;
  localparam int C5_LSH  = 3 * DUR_FRAC + OUT_FRAC;
  localparam int QUO_W   = OUT_W;
  localparam int DIV_X_W = MAG_W + C5_LSH;
  localparam int DIV_D_W = D5_W + RSH;
  localparam int DIV_LAT = QUO_W + 1;

  localparam int FRONT_STAGES = 7;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_LAT;

  localparam logic signed [OUT_W-1:0] COEF_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] COEF_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

@@ src/qtc_div.sv @@
module qtc_div import qtc_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [DIV_X_W-1:0]      dividend,
  input  logic [DIV_D_W-1:0]      divisor,
  input  logic                    neg,
  output logic signed [OUT_W-1:0] coef,
  output logic                    sat
);

  logic [DIV_D_W-1:0] rem_r [0:QUO_W-1];
  logic [QUO_W-1:0]   lo_r  [0:QUO_W-1];
  logic [QUO_W-1:0]   quo_r [1:QUO_W];
  logic               neg_r [0:QUO_W];
  logic               ovf_r [0:QUO_W];
  logic               over;
  logic [QUO_W-1:0]   q;

  // Quotient beyond 64 bits means saturation; the high part also seeds the remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DIV_D_W'(dividend[DIV_X_W-1:QUO_W]);
      lo_r[0]  <= dividend[QUO_W-1:0];
      neg_r[0] <= neg;
      ovf_r[0] <= DIV_D_W'(dividend[DIV_X_W-1:QUO_W]) >= divisor;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;
    logic [QUO_W-1:0]   qin;

    assign trial = {rem_r[j], lo_r[j][QUO_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    if (j == 0) begin : g_first
      assign qin = '0;
    end else begin : g_next
      assign qin = quo_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j+1] <= {qin[QUO_W-2:0], ge};
        neg_r[j+1] <= neg_r[j];
        ovf_r[j+1] <= ovf_r[j];
      end
    end

    if (j < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
          lo_r[j+1]  <= {lo_r[j][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign q    = quo_r[QUO_W];
  assign over = ovf_r[QUO_W]
              | (!neg_r[QUO_W] & q[QUO_W-1])
              | (neg_r[QUO_W] & q[QUO_W-1] & (|q[QUO_W-2:0]));

  always_comb begin
    if (over) begin
      coef = neg_r[QUO_W] ? COEF_MIN : COEF_MAX;
    end else if (neg_r[QUO_W]) begin
      coef = -$signed(q);
    end else begin
      coef = $signed(q);
    end
  end

  assign sat = over;

endmodule

@@ src/quintic_trajectory_coefficients.sv @@
// Quintic jerk-minimizing trajectory coefficients.
//
// Input stream: one transfer carries start and end position, velocity and
// acceleration (signed Q23.16). Result stream: one transfer per input with
// the six coefficients c0..c5 (signed Q31.32, truncated toward zero) and a
// flag in out_tuser that is set when any coefficient was clipped.
// cfg_we/cfg_wdata write the duration T (unsigned Q8.16); a write of zero is
// dropped. Write it only while no item is in flight.
//
// The path from input transfer to out_tvalid: seven stages form the boundary
// terms and numerators, then a 65-stage restoring divider (an entry stage,
// then one quotient bit per stage) divides by T^3, T^4 and T^5, then the
// output register. Throughput is one item per cycle unless the output stalls.
// Powers of T come from a free-running chain that settles after a duration
// write, before any new item reaches the dividers.
// Reset clears all valid bits and loads T = 2.5 s. When the receiver stalls
// a waiting result, the whole pipeline holds and in_tready drops; nothing is
// lost or repeated.
module quintic_trajectory_coefficients import qtc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc (40 bits each)
  input  logic [239:0]     in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // coef0, coef1, coef2, coef3, coef4, coef5 (64 bits each)
  output logic [383:0]     out_tdata,
  // saturated
  output logic             out_tuser,
  input  logic             cfg_we,
  input  logic [DUR_W-1:0] cfg_wdata
);

  typedef struct packed {
    logic signed [IN_W-1:0] xs;
    logic signed [IN_W-1:0] vs;
    logic signed [IN_W-1:0] as;
  } low_coef_t;

  logic                 adv;
  logic [DUR_W-1:0]     dur_r;
  logic signed [DUR_W:0] dur_s;

  // Duration power chain.
  logic [D2_W-1:0] pw_d2_r;
  logic [D2_W-1:0] p3_r [0:1];
  logic [D3_W-1:0] pw_d3_r;
  logic [D2_W-1:0] p4_r [0:2];
  logic [D4_W-1:0] pw_d4_r;
  logic [D2_W-1:0] p5_r [0:3];
  logic [D5_W-1:0] pw_d5_r;
  logic [D4_W-1:0] d4_nxt;
  logic [D5_W-1:0] d5_nxt;

  logic signed [IN_W-1:0] xs, vs, as, xe, ve, ae;

  // Front stages.
  logic signed [DIFF_W-1:0]  s1_dx_r, s1_dv_r, s1_da_r;
  logic signed [PRD_W-1:0]   s1_vd_r, s1_ad_r;
  logic signed [IN_W-1:0]    s1_as_r;
  logic signed [H0P_W-1:0]   s2_h0p_r, s2_h0p_nxt;
  logic signed [H1_W-1:0]    s2_h1_r, s2_h1_nxt;
  logic signed [IN_W+DUR_W:0]   s2_ma_lo_r, s2_ma_hi_r;
  logic signed [DIFF_W+DUR_W:0] s2_me_lo_r, s2_me_hi_r;
  logic signed [DUR_W:0]     d2_lo_s, d2_hi_s;
  logic signed [TERM_W-1:0]  s3_h0_r, s3_h0_nxt, s3_dd_r, s3_dd_nxt;
  logic signed [H1_LO+DUR_W+1:0]  s3_m1_lo_r;
  logic signed [H1_W-H1_LO+DUR_W:0] s3_m1_hi_r;
  logic signed [H1_LO:0]     h1_lo_s;
  logic signed [H1_W-H1_LO-1:0] h1_hi_s;
  logic signed [TERM_W-1:0]  s4_h0_r, s4_dd_r, s4_dh_r, s4_dh_nxt;
  logic signed [NUM_W-1:0]   n3_nxt, n4_nxt, n5_nxt;
  logic signed [NUM_W-1:0]   s5_n3_r, s5_n4_r, s5_n5_r;
  logic [MAG_W-1:0]          s6_m3_r, s6_m4_r, s6_m5_r;
  logic                      s6_g3_r, s6_g4_r, s6_g5_r;
  logic [DIV_X_W-1:0]        s7_x3_r, s7_x4_r, s7_x5_r;
  logic                      s7_g3_r, s7_g4_r, s7_g5_r;

  logic [DIV_D_W-1:0]        dv3, dv4, dv5;
  logic signed [OUT_W-1:0]   c3, c4, c5;
  logic                      sat3, sat4, sat5;
  logic signed [OUT_W-1:0]   c0, c1, c2;

  logic [PIPE_DEPTH-1:0]     vld_r;
  low_coef_t                 dly_r [0:PIPE_DEPTH-1];
  low_coef_t                 lc;

  logic                      out_valid_r;
  logic [383:0]              out_data_r;
  logic                      out_sat_r;

  // Advance when the output register is free or being emptied.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= DUR_RESET;
    end else if (cfg_we && (cfg_wdata != '0)) begin
      dur_r <= cfg_wdata;
    end
  end

  assign dur_s = $signed({1'b0, dur_r});

  // Powers of T, split into 24-bit partial products.
  always_comb begin
    d4_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      d4_nxt = d4_nxt + (D4_W'(p4_r[k]) << (k * DUR_W));
    end
    d5_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      d5_nxt = d5_nxt + (D5_W'(p5_r[k]) << (k * DUR_W));
    end
  end

  always_ff @(posedge clk) begin
    pw_d2_r <= dur_r * dur_r;
    p3_r[0] <= pw_d2_r[DUR_W-1:0] * dur_r;
    p3_r[1] <= pw_d2_r[D2_W-1:DUR_W] * dur_r;
    pw_d3_r <= D3_W'(p3_r[0]) + (D3_W'(p3_r[1]) << DUR_W);
    for (int k = 0; k < 3; k++) begin
      p4_r[k] <= pw_d3_r[k*DUR_W +: DUR_W] * dur_r;
    end
    pw_d4_r <= d4_nxt;
    for (int k = 0; k < 4; k++) begin
      p5_r[k] <= pw_d4_r[k*DUR_W +: DUR_W] * dur_r;
    end
    pw_d5_r <= d5_nxt;
  end

  assign xs = $signed(in_tdata[0*IN_W +: IN_W]);
  assign vs = $signed(in_tdata[1*IN_W +: IN_W]);
  assign as = $signed(in_tdata[2*IN_W +: IN_W]);
  assign xe = $signed(in_tdata[3*IN_W +: IN_W]);
  assign ve = $signed(in_tdata[4*IN_W +: IN_W]);
  assign ae = $signed(in_tdata[5*IN_W +: IN_W]);

  assign d2_lo_s = $signed({1'b0, pw_d2_r[DUR_W-1:0]});
  assign d2_hi_s = $signed({1'b0, pw_d2_r[D2_W-1:DUR_W]});
  assign h1_lo_s = $signed({1'b0, s2_h1_r[H1_LO-1:0]});
  assign h1_hi_s = s2_h1_r[H1_W-1:H1_LO];

  always_comb begin
    // h0 without the acceleration term, and h1
    s2_h0p_nxt = (H0P_W'(s1_dx_r) <<< (2*DUR_FRAC + 1))
               - (H0P_W'(s1_vd_r) <<< (DUR_FRAC + 1));
    s2_h1_nxt  = (H1_W'(s1_dv_r) <<< DUR_FRAC) - H1_W'(s1_ad_r);
    s3_h0_nxt  = TERM_W'(s2_h0p_r) - TERM_W'(s2_ma_lo_r)
               - (TERM_W'(s2_ma_hi_r) <<< DUR_W);
    s3_dd_nxt  = TERM_W'(s2_me_lo_r) + (TERM_W'(s2_me_hi_r) <<< DUR_W);
    s4_dh_nxt  = TERM_W'(s3_m1_lo_r) + (TERM_W'(s3_m1_hi_r) <<< H1_LO);
    n3_nxt = NUM_W'(s4_h0_r) * 10 - NUM_W'(s4_dh_r) * 8 + NUM_W'(s4_dd_r);
    n4_nxt = NUM_W'(s4_dh_r) * 14 - NUM_W'(s4_h0_r) * 15 - NUM_W'(s4_dd_r) * 2;
    n5_nxt = NUM_W'(s4_h0_r) * 6 - NUM_W'(s4_dh_r) * 6 + NUM_W'(s4_dd_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= DIFF_W'(xe) - DIFF_W'(xs);
      s1_dv_r <= DIFF_W'(ve) - DIFF_W'(vs);
      s1_da_r <= DIFF_W'(ae) - DIFF_W'(as);
      s1_vd_r <= vs * dur_s;
      s1_ad_r <= as * dur_s;
      s1_as_r <= as;

      s2_h0p_r   <= s2_h0p_nxt;
      s2_h1_r    <= s2_h1_nxt;
      s2_ma_lo_r <= s1_as_r * d2_lo_s;
      s2_ma_hi_r <= s1_as_r * d2_hi_s;
      s2_me_lo_r <= s1_da_r * d2_lo_s;
      s2_me_hi_r <= s1_da_r * d2_hi_s;

      s3_h0_r    <= s3_h0_nxt;
      s3_dd_r    <= s3_dd_nxt;
      s3_m1_lo_r <= h1_lo_s * dur_s;
      s3_m1_hi_r <= h1_hi_s * dur_s;

      s4_h0_r <= s3_h0_r;
      s4_dd_r <= s3_dd_r;
      s4_dh_r <= s4_dh_nxt;

      s5_n3_r <= n3_nxt;
      s5_n4_r <= n4_nxt;
      s5_n5_r <= n5_nxt;

      // magnitude and sign for the unsigned divider
      s6_g3_r <= s5_n3_r[NUM_W-1];
      s6_g4_r <= s5_n4_r[NUM_W-1];
      s6_g5_r <= s5_n5_r[NUM_W-1];
      s6_m3_r <= s5_n3_r[NUM_W-1] ? MAG_W'(-s5_n3_r) : MAG_W'(s5_n3_r);
      s6_m4_r <= s5_n4_r[NUM_W-1] ? MAG_W'(-s5_n4_r) : MAG_W'(s5_n4_r);
      s6_m5_r <= s5_n5_r[NUM_W-1] ? MAG_W'(-s5_n5_r) : MAG_W'(s5_n5_r);

      s7_g3_r <= s6_g3_r;
      s7_g4_r <= s6_g4_r;
      s7_g5_r <= s6_g5_r;
      s7_x3_r <= DIV_X_W'(s6_m3_r) << C3_LSH;
      s7_x4_r <= DIV_X_W'(s6_m4_r) << C4_LSH;
      s7_x5_r <= DIV_X_W'(s6_m5_r) << C5_LSH;
    end
  end

  assign dv3 = DIV_D_W'(pw_d3_r) << RSH;
  assign dv4 = DIV_D_W'(pw_d4_r) << RSH;
  assign dv5 = DIV_D_W'(pw_d5_r) << RSH;

  qtc_div u_div3 (
    .clk(clk), .en(adv), .dividend(s7_x3_r), .divisor(dv3), .neg(s7_g3_r),
    .coef(c3), .sat(sat3)
  );

  qtc_div u_div4 (
    .clk(clk), .en(adv), .dividend(s7_x4_r), .divisor(dv4), .neg(s7_g4_r),
    .coef(c4), .sat(sat4)
  );

  qtc_div u_div5 (
    .clk(clk), .en(adv), .dividend(s7_x5_r), .divisor(dv5), .neg(s7_g5_r),
    .coef(c5), .sat(sat5)
  );

  // Hold start state alongside the pipeline for c0..c2.
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= '{xs: xs, vs: vs, as: as};
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign lc = dly_r[PIPE_DEPTH-1];
  assign c0 = OUT_W'(lc.xs) <<< (OUT_FRAC - IN_FRAC);
  assign c1 = OUT_W'(lc.vs) <<< (OUT_FRAC - IN_FRAC);
  assign c2 = OUT_W'(lc.as) <<< (OUT_FRAC - IN_FRAC - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {c5, c4, c3, c2, c1, c0};
      out_sat_r  <= sat3 | sat4 | sat5;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

@@ src/qtc_checker.sv @@
module qtc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [383:0] out_tdata,
  input logic         out_tuser
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with free output register");

endmodule

bind quintic_trajectory_coefficients qtc_checker u_qtc_checker (.*);

@@ dv/tb_quintic_trajectory_coefficients.sv @@
module tb_quintic_trajectory_coefficients import qtc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for every numerator shifted left and every power of T.
  typedef logic signed [319:0] wide_t;
  // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc
  typedef logic [5:0][IN_W-1:0] boundary_t;

  typedef struct {
    logic [5:0][OUT_W-1:0] coef;
    logic                  sat;
  } coef_set_t;

  localparam int DRAIN_CYCLES = PIPE_DEPTH + 10;
  localparam int STALL_LIMIT  = 5000;
  localparam int N_RANDOM     = 1250;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [239:0]          in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [383:0]          out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [DUR_W-1:0]      cfg_wdata;

  coef_set_t             pending_coefs[$];
  logic [DUR_W-1:0]      model_duration;
  int                    error_count;
  int                    idle_cycles = 0;
  bit                    no_idle;

  quintic_trajectory_coefficients u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clip a quotient to the signed 64-bit range and flag the clip.
  function automatic logic [OUT_W-1:0] clip_coef(wide_t q, inout logic sat);
    wide_t hi;
    wide_t lo;
    hi = COEF_MAX;
    lo = COEF_MIN;
    if (q > hi) begin
      sat = 1'b1;
      return COEF_MAX;
    end
    if (q < lo) begin
      sat = 1'b1;
      return COEF_MIN;
    end
    return q[OUT_W-1:0];
  endfunction

  // trunc(n * 2^lsh / (T^k * 2^rsh)); signed division truncates toward zero.
  function automatic wide_t scaled_quotient(wide_t n, int lsh, int k, wide_t dw, int rsh);
    wide_t den;
    den = 1;
    for (int i = 0; i < k; i++) den = den * dw;
    return (n <<< lsh) / (den <<< rsh);
  endfunction

  function automatic coef_set_t predict_coefs(boundary_t b, logic [DUR_W-1:0] d);
    coef_set_t r;
    wide_t pos_s, vel_s, acc_s, pos_e, vel_e, acc_e, dw;
    wide_t h0, h1, dh1, ddh2, n3, n4, n5;
    logic  sat;
    pos_s = $signed(b[0]);
    vel_s = $signed(b[1]);
    acc_s = $signed(b[2]);
    pos_e = $signed(b[3]);
    vel_e = $signed(b[4]);
    acc_e = $signed(b[5]);
    dw    = d;
    sat   = 1'b0;
    // Boundary residues; numerators on the scale 2^(IN_FRAC+1) * 2^(2*DUR_FRAC).
    h0   = ((pos_e - pos_s) <<< (2 * DUR_FRAC + 1)) - ((vel_s * dw) <<< (DUR_FRAC + 1))
           - acc_s * dw * dw;
    h1   = ((vel_e - vel_s) <<< DUR_FRAC) - acc_s * dw;
    dh1  = h1 * dw;
    ddh2 = (acc_e - acc_s) * dw * dw;
    n3   = 10 * h0 - 8 * dh1 + ddh2;
    n4   = -15 * h0 + 14 * dh1 - 2 * ddh2;
    n5   = 6 * h0 - 6 * dh1 + ddh2;
    r.coef[0] = clip_coef(scaled_quotient(pos_s, OUT_FRAC, 0, dw, IN_FRAC), sat);
    r.coef[1] = clip_coef(scaled_quotient(vel_s, OUT_FRAC, 0, dw, IN_FRAC), sat);
    r.coef[2] = clip_coef(scaled_quotient(acc_s, OUT_FRAC, 0, dw, IN_FRAC + 1), sat);
    r.coef[3] = clip_coef(scaled_quotient(n3, C3_LSH, 3, dw, RSH), sat);
    r.coef[4] = clip_coef(scaled_quotient(n4, C4_LSH, 4, dw, RSH), sat);
    r.coef[5] = clip_coef(scaled_quotient(n5, C5_LSH, 5, dw, RSH), sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    error_count++;
    $display("MISMATCH %s: got %h, want %h", what, got, want);
  endtask

  // Present one boundary set after a random gap and hold it until the transfer.
  task automatic send_item(boundary_t b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    pending_coefs.insert(pending_coefs.size(), predict_coefs(b, model_duration));
  endtask

  // Drain the pipeline, then write the duration while nothing is in flight.
  task automatic write_duration(logic [DUR_W-1:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_coefs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    // A zero write is dropped by the block.
    if (value != '0) model_duration = value;
  endtask

  function automatic logic [IN_W-1:0] rand_field();
    logic [IN_W-1:0] v;
    v = IN_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 9))
      0:       v = {1'b0, {(IN_W-1){1'b1}}};
      1:       v = {1'b1, {(IN_W-1){1'b0}}};
      2, 3:    v = v;
      default: v = IN_W'($signed($urandom_range(0, 2000000)) - 1000000) <<< $urandom_range(0, 8);
    endcase
    return v;
  endfunction

  function automatic boundary_t rand_boundary();
    boundary_t b;
    for (int i = 0; i < 6; i++) b[i] = rand_field();
    return b;
  endfunction

  task automatic test_field_extremes();
    boundary_t b;
    send_item('0);
    send_item({6{ {1'b0, {(IN_W-1){1'b1}}} }});
    send_item({6{ {1'b1, {(IN_W-1){1'b0}}} }});
    send_item({6{ {IN_W{1'b1}} }});
    for (int i = 0; i < 6; i++) begin
      b = '0;
      b[i] = {1'b0, {(IN_W-1){1'b1}}};
      send_item(b);
      b[i] = {1'b1, {(IN_W-1){1'b0}}};
      send_item(b);
    end
    // Rest-to-rest move of one unit.
    b = '0;
    b[3] = IN_W'(1 << IN_FRAC);
    send_item(b);
  endtask

  task automatic test_duration_sweep();
    logic [DUR_W-1:0] settings[6];
    settings = '{DUR_W'(1), {DUR_W{1'b1}}, DUR_W'(65536), DUR_W'(1234567),
                 DUR_W'(16), DUR_RESET};
    foreach (settings[i]) begin
      write_duration(settings[i]);
      repeat (4) send_item(rand_boundary());
      if (i == 0) begin
        // Tiny T: expect saturation on the higher terms.
        send_item({6{ {1'b0, {(IN_W-1){1'b1}}} }});
      end
    end
    // Zero write is dropped; T stays as it was.
    write_duration('0);
    repeat (4) send_item(rand_boundary());
  endtask

  task automatic test_random_items();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 250 == 125) write_duration(DUR_WIDTH_RAND());
      // Stretches with no idling on either side.
      if (i % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_item(rand_boundary());
    end
    no_idle = 1'b0;
  endtask

  function automatic logic [DUR_W-1:0] DUR_WIDTH_RAND();
    case ($urandom_range(0, 3))
      0:       return DUR_W'($urandom_range(1, 255));
      1:       return DUR_W'($urandom_range(32768, 1048576));
      default: return DUR_W'($urandom());
    endcase
  endfunction

  // Receiver: stall a random number of cycles per result, then check it.
  initial begin
    coef_set_t want;
    int gap;
    out_tready = 1'b0;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_tvalid) break;
      end
      if (pending_coefs.size() == 0) begin
        report_mismatch("unexpected result transfer", out_tdata[OUT_W-1:0], '0);
      end else begin
        want = pending_coefs.pop_front();
        for (int i = 0; i < 6; i++)
          if (out_tdata[i*OUT_W +: OUT_W] !== want.coef[i])
            report_mismatch($sformatf("coef%0d", i), out_tdata[i*OUT_W +: OUT_W], want.coef[i]);
        if (out_tuser !== want.sat)
          report_mismatch("saturated", OUT_W'(out_tuser), OUT_W'(want.sat));
      end
    end
  end

  // Watchdog: count cycles with no transfer on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_quintic_trajectory_coefficients: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    model_duration = DUR_RESET;
    error_count    = 0;
    no_idle        = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_duration_sweep();
    test_random_items();

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_coefs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_quintic_trajectory_coefficients: done, clean");
    end else begin
      $display("tb_quintic_trajectory_coefficients: done, errors");
    end
    $finish;
  end

endmodule

@@ quintic_trajectory_coefficients.f @@
src/qtc_pkg.sv
src/qtc_div.sv
src/quintic_trajectory_coefficients.sv
src/qtc_checker.sv
dv/tb_quintic_trajectory_coefficients.sv
